// ----- rtl/core/drr_pkg.sv -----
// shared types and constants of the deficit round robin scheduler
package drr_pkg;

  localparam int MAX_CONNS_DEF    = 16;
  localparam int DEFICIT_BITS_DEF = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd160;

  typedef enum logic [2:0] {
    K_ACTIVATE = 3'd0,
    K_REMOVE   = 3'd1,
    K_SET_ELIG = 3'd2,
    K_START    = 3'd3,
    K_GRANT    = 3'd4,
    K_COMMIT   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACK    = 2'd0,
    ST_REQ    = 2'd1,
    ST_DONE   = 2'd2,
    ST_EXCESS = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EDIT,
    CMD_ACK,
    CMD_CFIND,
    CMD_CSHIFT,
    CMD_COPY,
    CMD_WALK,
    CMD_GRANT,
    CMD_WSHIFT,
    CMD_BACK
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_SHIFT,
    S_COPY,
    S_WALK,
    S_ERASE,
    S_BACK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       c_ok;
    logic       idx_end;
    logic       match;
    logic       cmore;
    logic       wmore;
    logic       copy_last;
    logic       walk_skip;
    logic       busy;
    logic       wempty;
    logic       gover;
    logic       gdrop;
    logic       stop;
    logic       wvalid;
  } dp_status_t;

endpackage

// ----- rtl/core/drr_ctrl.sv -----
// sequencing state machine of the deficit round robin scheduler
module drr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  drr_pkg::dp_status_t sts,
  output drr_pkg::cmd_t      cmd
);
  import drr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.kind) inside
          K_ACTIVATE, K_REMOVE: state_next = sts.c_ok ? S_FIND : S_OUT;
          K_START: state_next = S_COPY;
          K_GRANT: begin
            if (!sts.busy || sts.wempty || sts.gover) state_next = S_OUT;
            else if (sts.gdrop) state_next = S_ERASE;
            else if (sts.stop) state_next = S_OUT;
            else state_next = S_WALK;
          end
          K_COMMIT: state_next = sts.wvalid ? S_BACK : S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_FIND: begin
        if (sts.idx_end) state_next = S_OUT;
        else if (sts.match) state_next = (sts.kind == K_ACTIVATE) ? S_OUT : S_SHIFT;
      end
      S_SHIFT: begin
        if (!sts.cmore) state_next = S_OUT;
      end
      S_COPY: begin
        if (sts.copy_last) state_next = S_WALK;
      end
      S_WALK: begin
        if (!sts.walk_skip) state_next = S_OUT;
      end
      S_ERASE: begin
        if (!sts.wmore) state_next = sts.stop ? S_OUT : S_WALK;
      end
      S_BACK: begin
        if (sts.copy_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd = CMD_LATCH;
      end
      S_DISPATCH: begin
        case (sts.kind) inside
          K_ACTIVATE, K_REMOVE, K_SET_ELIG: cmd = CMD_EDIT;
          K_START: cmd = CMD_NONE;
          K_GRANT: cmd = CMD_GRANT;
          K_COMMIT: cmd = sts.wvalid ? CMD_NONE : CMD_ACK;
          default: cmd = CMD_ACK;
        endcase
      end
      S_FIND:  cmd = CMD_CFIND;
      S_SHIFT: cmd = CMD_CSHIFT;
      S_COPY:  cmd = CMD_COPY;
      S_WALK:  cmd = CMD_WALK;
      S_ERASE: cmd = CMD_WSHIFT;
      S_BACK:  cmd = CMD_BACK;
      S_OUT:   m_tvalid = 1'b1;
      default: cmd = CMD_NONE;
    endcase
  end

endmodule

// ----- rtl/core/drr_dp.sv -----
// ring, deficit tables, working copy and result register of the scheduler
module drr_dp #(
  parameter int MAX_CONNS    = drr_pkg::MAX_CONNS_DEF,
  parameter int DEFICIT_BITS = drr_pkg::DEFICIT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  drr_pkg::cmd_t       cmd,
  output drr_pkg::dp_status_t sts,
  input  logic [2:0]          in_kind,
  input  logic [3:0]          in_conn,
  input  logic                in_flag,
  input  logic [15:0]         in_granted,
  input  logic                in_stop,
  input  logic                in_act,
  input  logic                in_elig,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  output drr_pkg::st_t        res_st,
  output logic [3:0]          res_conn,
  output logic [15:0]         res_def
);
  import drr_pkg::*;

  localparam int IW = $clog2(MAX_CONNS);
  localparam int CW = $clog2(MAX_CONNS + 1);
  localparam int DB = DEFICIT_BITS;
  localparam int SW = ((DB > 16) ? DB : 16) + 1;
  localparam logic [SW-1:0] DEF_MAX = {{(SW-DB){1'b0}}, {DB{1'b1}}};
  localparam logic [SW-1:0] OUT_MAX = SW'(17'h0FFFF);
  localparam logic [CW-1:0] N_C     = CW'(MAX_CONNS);
  localparam logic [CW-1:0] LAST_C  = CW'(MAX_CONNS - 1);

  logic [15:0]   quantum;
  // committed state
  logic [IW-1:0] ring [MAX_CONNS];
  logic [CW-1:0] cnt;
  logic [IW-1:0] ptr;
  logic [DB-1:0] def  [MAX_CONNS];
  logic          elig [MAX_CONNS];
  logic          act  [MAX_CONNS];
  // working copy
  logic [IW-1:0] wring [MAX_CONNS];
  logic [CW-1:0] wcnt;
  logic [IW-1:0] wptr;
  logic [DB-1:0] wdef  [MAX_CONNS];
  logic          welig [MAX_CONNS];
  logic          wact  [MAX_CONNS];
  logic          wvalid;
  logic [CW-1:0] el_left;
  logic          busy;
  // sweep index and latched item
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [2:0]    l_kind;
  logic [3:0]    l_conn;
  logic          l_flag;
  logic [15:0]   l_g;
  logic          l_stop;
  logic          l_act;
  logic          l_el;

  function automatic logic [15:0] sat16(input logic [DB-1:0] d);
    return (SW'(d) > OUT_MAX) ? 16'hFFFF : 16'(d);
  endfunction

  logic [IW-1:0] ci, ridx, nridx, wp, np, p1;
  logic [CW-1:0] nidx;
  logic          c_ok;
  logic [IW-1:0] cc;
  logic [DB-1:0] wd, dsat, newdef;
  logic [SW-1:0] sum;
  logic          walk_go, keepq;

  always_comb begin
    ci      = IW'(l_conn);
    c_ok    = ({28'd0, l_conn} < 32'(MAX_CONNS));
    ridx    = idx[IW-1:0];
    nidx    = idx + CW'(1);
    nridx   = nidx[IW-1:0];
    wp      = (CW'(wptr) >= wcnt) ? '0 : wptr;
    np      = ((CW'(wp) + CW'(1)) >= wcnt) ? '0 : IW'(CW'(wp) + CW'(1));
    cc      = wring[wp];
    wd      = wdef[cc];
    sum     = SW'(wd) + SW'(quantum);
    dsat    = (sum > DEF_MAX) ? DB'(DEF_MAX) : DB'(sum);
    newdef  = wd - DB'(l_g);
    keepq   = l_stop && (SW'(newdef) >= SW'(quantum));
    walk_go = (wcnt != '0) && (el_left != '0);
    p1      = (pos < CW'(ptr)) ? (ptr - IW'(1)) : ptr;
  end

  always_comb begin
    sts.kind      = l_kind;
    sts.c_ok      = c_ok;
    sts.idx_end   = (idx == cnt);
    sts.match     = (ring[ridx] == ci);
    sts.cmore     = (nidx < cnt);
    sts.wmore     = (nidx < wcnt);
    sts.copy_last = (idx == LAST_C);
    sts.walk_skip = walk_go && !welig[cc];
    sts.busy      = busy;
    sts.wempty    = (wcnt == '0);
    sts.gover     = (SW'(l_g) > SW'(wd));
    sts.gdrop     = !l_act;
    sts.stop      = l_stop;
    sts.wvalid    = wvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
      cnt     <= '0;
      ptr     <= '0;
      wcnt    <= '0;
      wvalid  <= 1'b0;
      el_left <= '0;
      busy    <= 1'b0;
      for (int i = 0; i < MAX_CONNS; i++) begin
        def[i]  <= '0;
        elig[i] <= 1'b0;
        act[i]  <= 1'b0;
      end
    end else begin
      if (cfg_we) quantum <= cfg_data;
      case (cmd)
        CMD_LATCH: begin
          l_kind <= in_kind;
          l_conn <= in_conn;
          l_flag <= in_flag;
          l_g    <= in_granted;
          l_stop <= in_stop;
          l_act  <= in_act;
          l_el   <= in_elig;
          idx    <= '0;
        end
        CMD_EDIT: begin
          if (c_ok) begin
            case (l_kind)
              K_ACTIVATE: begin
                act[ci]  <= 1'b1;
                elig[ci] <= 1'b1;
              end
              K_REMOVE: act[ci] <= 1'b0;
              default: elig[ci] <= l_flag;
            endcase
          end
          res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
        end
        CMD_ACK: begin
          res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
        end
        CMD_CFIND: begin
          if (idx == cnt) begin
            if (l_kind == K_ACTIVATE && cnt != N_C) begin
              ring[cnt[IW-1:0]] <= ci;
              cnt <= cnt + CW'(1);
            end
            res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
          end else if (ring[ridx] == ci) begin
            pos <= idx;
            res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
          end else begin
            idx <= nidx;
          end
        end
        CMD_CSHIFT: begin
          if (nidx < cnt) begin
            ring[ridx] <= ring[nridx];
            idx <= nidx;
          end else begin
            cnt <= cnt - CW'(1);
            ptr <= (CW'(p1) >= (cnt - CW'(1))) ? '0 : p1;
            res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
          end
        end
        CMD_COPY: begin
          wring[ridx] <= ring[ridx];
          wdef[ridx]  <= def[ridx];
          welig[ridx] <= elig[ridx];
          wact[ridx]  <= act[ridx];
          idx <= nidx;
          if (idx == LAST_C) begin
            wcnt    <= cnt;
            wptr    <= ptr;
            wvalid  <= 1'b1;
            el_left <= cnt;
            busy    <= 1'b1;
          end
        end
        CMD_BACK: begin
          ring[ridx] <= wring[ridx];
          def[ridx]  <= wdef[ridx];
          elig[ridx] <= welig[ridx];
          act[ridx]  <= wact[ridx];
          idx <= nidx;
          if (idx == LAST_C) begin
            cnt <= wcnt;
            ptr <= wptr;
            res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
          end
        end
        CMD_WALK: begin
          if (walk_go) begin
            if (!welig[cc]) begin
              wptr    <= np;
              el_left <= el_left - CW'(1);
            end else begin
              wptr     <= wp;
              wdef[cc] <= dsat;
              res_st   <= ST_REQ;
              res_conn <= 4'(cc);
              res_def  <= sat16(dsat);
            end
          end else begin
            busy <= 1'b0;
            res_st <= ST_DONE; res_conn <= '0; res_def <= '0;
          end
        end
        CMD_GRANT: begin
          if (!busy) begin
            res_st <= ST_ACK; res_conn <= '0; res_def <= '0;
          end else if (wcnt == '0) begin
            busy <= 1'b0;
            res_st <= ST_DONE; res_conn <= '0; res_def <= '0;
          end else if (SW'(l_g) > SW'(wd)) begin
            wptr     <= wp;
            busy     <= 1'b0;
            res_st   <= ST_EXCESS;
            res_conn <= 4'(cc);
            res_def  <= sat16(wd);
          end else begin
            if (!l_el || !l_act) begin
              if (el_left != '0) el_left <= el_left - CW'(1);
              welig[cc] <= 1'b0;
            end
            if (!l_act) begin
              // entry drops out, the shift sweep starts at its place
              wptr     <= wp;
              wdef[cc] <= '0;
              wact[cc] <= 1'b0;
              idx      <= CW'(wp);
            end else if (keepq) begin
              wptr     <= wp;
              wdef[cc] <= newdef - DB'(quantum);
            end else begin
              wptr     <= np;
              wdef[cc] <= newdef;
            end
            if (l_act && l_stop) begin
              busy <= 1'b0;
              res_st <= ST_DONE; res_conn <= '0; res_def <= '0;
            end
          end
        end
        CMD_WSHIFT: begin
          if (nidx < wcnt) begin
            wring[ridx] <= wring[nridx];
            idx <= nidx;
          end else begin
            wcnt <= wcnt - CW'(1);
            if (CW'(wptr) >= (wcnt - CW'(1))) wptr <= '0;
            if (l_stop) begin
              busy <= 1'b0;
              res_st <= ST_DONE; res_conn <= '0; res_def <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/deficit_round_robin_scheduler.sv -----
// top level of the deficit round robin scheduler
//
// usage:
//  - items arrive on the s_ group; s_tuser carries the kind (activate, remove,
//    set eligibility, start round, grant response, commit)
//  - every item produces exactly one result transfer on the m_ group; m_tuser
//    carries the status (ack, grant request, round finished, excess grant)
//  - the quantum is written on the cfg_ channel, always ready; write it only
//    while the block is idle
//  - one item at a time: s_tready is high only while no item is in work and
//    no result is waiting
// steps, the ring and tables being swept one entry per cycle:
//  - set eligibility, grant response without walk, commit without a round: dispatch only
//  - activate/remove: dispatch, then a search of the ring and, for remove, a shift
//  - start round: copy of all MAX_CONNS entries, then a walk over skipped entries
//  - commit: copy-back of all MAX_CONNS entries
//  - a grant that drops the entry adds a shift of the working ring
// and each item ends with its result transfer
// reset clears the ring, tables, round and quantum (160); a stalled receiver
// holds the result in the output register and blocks further input
module deficit_round_robin_scheduler #(
  parameter int MAX_CONNS    = drr_pkg::MAX_CONNS_DEF,
  parameter int DEFICIT_BITS = drr_pkg::DEFICIT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // conn_index[3:0], eligible_flag[4], granted_bytes[20:5], stop_round[21],
  // still_active[22], still_eligible[23]
  input  logic [23:0] s_tdata,
  // kind[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // req_conn[3:0], req_deficit[19:4], zero fill [23:20]
  output logic [23:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import drr_pkg::*;

  cmd_t       cmd;
  dp_status_t sts;
  st_t        res_st;
  logic [3:0] res_conn;
  logic [15:0] res_def;

  // quantum register takes every write
  assign cfg_ready = 1'b1;

  drr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  drr_dp #(
    .MAX_CONNS    (MAX_CONNS),
    .DEFICIT_BITS (DEFICIT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (s_tuser),
    .in_conn    (s_tdata[3:0]),
    .in_flag    (s_tdata[4]),
    .in_granted (s_tdata[20:5]),
    .in_stop    (s_tdata[21]),
    .in_act     (s_tdata[22]),
    .in_elig    (s_tdata[23]),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .res_st     (res_st),
    .res_conn   (res_conn),
    .res_def    (res_def)
  );

  // result register drives the master side directly
  assign m_tdata = {4'd0, res_def, res_conn};
  assign m_tuser = res_st;

endmodule

// ----- test/deficit_round_robin_scheduler_tb.sv -----
// testbench of the deficit round robin scheduler: directed cases, random rounds, quantum settings
`timescale 1ns / 1ps

module deficit_round_robin_scheduler_tb;
  import drr_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  conn;
    logic [15:0] deficit;
  } sched_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  deficit_round_robin_scheduler DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: committed ring and tables
  logic [15:0] quantum;
  int          ring_q[$];
  int          ring_ptr;
  logic [15:0] def_tab[16];
  logic        elig_tab[16];
  logic        act_tab[16];
  // working copy of a round
  int          wring_q[$];
  int          wptr;
  logic [15:0] wdef[16];
  logic        welig[16];
  logic        wact[16];
  logic        wvalid;
  int          elig_left;
  logic        busy;

  sched_result_t expected_q[$];
  sched_result_t last_pred;
  int          errors;
  int          n_items;
  int          n_results;
  int          n_requests;
  int          n_excess;
  logic        idling;
  int          rx_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int ptr_after_erase(int pos, int ptr, int cnt);
    if (pos < ptr) ptr--;
    if (ptr >= cnt) ptr = 0;
    return ptr;
  endfunction

  function automatic int next_pos(int p, int cnt);
    return (p + 1 >= cnt) ? 0 : p + 1;
  endfunction

  function automatic sched_result_t mk(logic [1:0] st, int c, int d);
    sched_result_t r;
    r.status  = st;
    r.conn    = c[3:0];
    r.deficit = d[15:0];
    return r;
  endfunction

  // walk the working ring from the pointer to the next eligible entry
  function automatic sched_result_t walk_ring();
    int c;
    logic [16:0] d;
    while (wring_q.size() > 0 && elig_left > 0) begin
      if (wptr >= wring_q.size()) wptr = 0;
      c = wring_q[wptr];
      if (!welig[c]) begin
        wptr = next_pos(wptr, wring_q.size());
        elig_left--;
        continue;
      end
      d = {1'b0, wdef[c]} + {1'b0, quantum};
      if (d[16]) d = 17'h0ffff;
      wdef[c] = d[15:0];
      return mk(ST_REQ, c, d);
    end
    busy = 1'b0;
    return mk(ST_DONE, 0, 0);
  endfunction

  function automatic sched_result_t grant_reply(logic [23:0] td);
    int c;
    int pos;
    logic [15:0] g;
    logic stop, still_act, still_el;
    g = td[20:5];
    stop = td[21];
    still_act = td[22];
    still_el = td[23];
    if (!busy) return mk(ST_ACK, 0, 0);
    if (wring_q.size() == 0) begin
      busy = 1'b0;
      return mk(ST_DONE, 0, 0);
    end
    if (wptr >= wring_q.size()) wptr = 0;
    c = wring_q[wptr];
    if (g > wdef[c]) begin
      busy = 1'b0;
      return mk(ST_EXCESS, c, wdef[c]);
    end
    wdef[c] = wdef[c] - g;
    if (!still_el || !still_act) begin
      if (elig_left > 0) elig_left--;
      welig[c] = 1'b0;
    end
    if (!still_act) begin
      pos = wptr;
      wring_q.delete(pos);
      wptr = ptr_after_erase(pos, wptr, wring_q.size());
      wdef[c] = '0;
      wact[c] = 1'b0;
    end else if (stop && wdef[c] >= quantum) begin
      wdef[c] = wdef[c] - quantum;
    end else begin
      wptr = next_pos(wptr, wring_q.size());
    end
    if (stop) begin
      busy = 1'b0;
      return mk(ST_DONE, 0, 0);
    end
    return walk_ring();
  endfunction

  function automatic sched_result_t predict_item(logic [2:0] k, logic [23:0] td);
    int c;
    int pos;
    c = td[3:0];
    case (k)
      K_ACTIVATE: begin
        act_tab[c] = 1'b1;
        elig_tab[c] = 1'b1;
        pos = -1;
        foreach (ring_q[i]) if (ring_q[i] == c && pos < 0) pos = i;
        if (pos < 0 && ring_q.size() < 16) ring_q.push_back(c);
      end
      K_REMOVE: begin
        pos = -1;
        foreach (ring_q[i]) if (ring_q[i] == c && pos < 0) pos = i;
        if (pos >= 0) begin
          ring_q.delete(pos);
          ring_ptr = ptr_after_erase(pos, ring_ptr, ring_q.size());
        end
        act_tab[c] = 1'b0;
      end
      K_SET_ELIG: elig_tab[c] = td[4];
      K_START: begin
        wring_q = ring_q;
        wptr = ring_ptr;
        for (int i = 0; i < 16; i++) begin
          wdef[i] = def_tab[i];
          welig[i] = elig_tab[i];
          wact[i] = act_tab[i];
        end
        wvalid = 1'b1;
        elig_left = ring_q.size();
        busy = 1'b1;
        return walk_ring();
      end
      K_GRANT: return grant_reply(td);
      K_COMMIT: begin
        if (wvalid) begin
          ring_q = wring_q;
          ring_ptr = wptr;
          for (int i = 0; i < 16; i++) begin
            def_tab[i] = wdef[i];
            elig_tab[i] = welig[i];
            act_tab[i] = wact[i];
          end
        end
      end
      default: ;
    endcase
    return mk(ST_ACK, 0, 0);
  endfunction

  // one item on the input stream; valid stays high when the next item follows at once
  task automatic send_item(logic [2:0] k, logic [23:0] td);
    s_tuser  <= k;
    s_tdata  <= td;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_pred = predict_item(k, td);
    expected_q.push_back(last_pred);
    n_items++;
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [23:0] pack_item(int c, int el, int g, int stop,
                                            int sa, int se);
    return {se[0], sa[0], stop[0], g[15:0], el[0], c[3:0]};
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] q);
    drain();
    cfg_data  <= q;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quantum = q;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // grant sized from the last request, mostly within the deficit
  task automatic grant_for_request(logic sa, logic se, logic stop);
    logic [15:0] g;
    if ($urandom_range(0, 11) == 0 && last_pred.deficit != 16'hffff)
      g = 16'($urandom_range(last_pred.deficit + 1, 65535));
    else if ($urandom_range(0, 3) == 0)
      g = last_pred.deficit;
    else
      g = 16'($urandom_range(0, last_pred.deficit));
    send_item(K_GRANT, pack_item($urandom_range(0, 15), $urandom_range(0, 1), g, stop, sa, se));
  endtask

  task automatic test_directed();
    send_item(K_COMMIT, '0);                           // commit with no round yet
    send_item(K_GRANT, pack_item(0, 0, 16'd5, 0, 1, 1)); // grant while idle
    send_item(K_START, '0);                            // round over an empty ring
    send_item(K_ACTIVATE, pack_item(0, 0, 0, 0, 0, 0));
    send_item(K_ACTIVATE, pack_item(15, 0, 0, 0, 0, 0));
    send_item(K_ACTIVATE, pack_item(7, 0, 0, 0, 0, 0));
    send_item(K_ACTIVATE, pack_item(7, 0, 0, 0, 0, 0)); // already in ring
    send_item(K_SET_ELIG, pack_item(15, 0, 0, 0, 0, 0));
    send_item(K_START, '0);
    send_item(K_GRANT, pack_item(0, 0, 16'd0, 0, 1, 1));  // zero grant
    send_item(K_GRANT, pack_item(0, 0, 16'd10, 1, 1, 1)); // stop with deficit left
    send_item(K_COMMIT, '0);
    send_item(K_START, '0);
    send_item(K_GRANT, pack_item(0, 0, 16'hffff, 0, 1, 1)); // full-size grant: excess unless the deficit is saturated
    send_item(K_START, '0);
    send_item(K_START, '0);                            // restart while busy
    send_item(K_REMOVE, pack_item(7, 0, 0, 0, 0, 0));  // edit during round
    send_item(K_GRANT, pack_item(0, 0, 16'd1, 0, 0, 1)); // entry drops out
    send_item(K_COMMIT, '0);                           // commit mid round
    send_item(K_GRANT, pack_item(0, 0, 16'd0, 0, 1, 0)); // becomes ineligible
    send_item(K_SET_ELIG, pack_item(15, 1, 0, 0, 0, 0));
    send_item(3'd6, 24'hffffff);
    send_item(3'd7, 24'h000000);
    send_item(K_REMOVE, pack_item(3, 0, 0, 0, 0, 0));  // slot not in ring
    send_item(K_COMMIT, '0);
  endtask

  // well-formed rounds with random content, plus noise and broken sequences
  task automatic test_random_rounds(int target);
    int grants;
    while (n_items < target) begin
      repeat ($urandom_range(0, 3))
        send_item(K_ACTIVATE, pack_item($urandom_range(0, 15), 0, 0, 0, 0, 0));
      if ($urandom_range(0, 2) == 0)
        send_item(K_SET_ELIG, pack_item($urandom_range(0, 15), $urandom_range(0, 1), 0, 0, 0, 0));
      if ($urandom_range(0, 4) == 0)
        send_item(K_REMOVE, pack_item($urandom_range(0, 15), 0, 0, 0, 0, 0));
      send_item(K_START, 24'($urandom()));
      grants = 0;
      while (last_pred.status == ST_REQ && grants < 40) begin
        if ($urandom_range(0, 9) == 0)
          send_item(3'($urandom_range(0, 7)), 24'($urandom()));
        else
          grant_for_request($urandom_range(0, 5) != 0, $urandom_range(0, 3) != 0,
                            $urandom_range(0, 7) == 0);
        grants++;
      end
      if ($urandom_range(0, 3) != 0) send_item(K_COMMIT, 24'($urandom()));
    end
  endtask

  // receiver stalls in bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      rx_stall <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker: every transfer against the oldest expectation
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: status %0d", m_tuser);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_results++;
        if (exp_r.status == ST_REQ) n_requests++;
        if (exp_r.status == ST_EXCESS) n_excess++;
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
          errors++;
        end
        if (m_tdata[3:0] !== exp_r.conn) begin
          $error("req_conn: expected %0d, actual %0d", exp_r.conn, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[19:4] !== exp_r.deficit) begin
          $error("req_deficit: expected %0d, actual %0d", exp_r.deficit, m_tdata[19:4]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idling = 1'b1;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_requests = 0;
    n_excess = 0;
    quantum = QUANTUM_RESET;
    ring_ptr = 0;
    wptr = 0;
    wvalid = 1'b0;
    elig_left = 0;
    busy = 1'b0;
    for (int i = 0; i < 16; i++) begin
      def_tab[i] = '0;
      elig_tab[i] = 1'b0;
      act_tab[i] = 1'b0;
      wdef[i] = '0;
      welig[i] = 1'b0;
      wact[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_quantum(16'hffff);   // saturation of the deficit
    test_directed();
    write_quantum(16'd1);
    test_random_rounds(400);
    write_quantum(16'd0);      // quantum of zero adds nothing
    test_random_rounds(600);
    write_quantum(16'($urandom_range(1, 65535)));
    test_random_rounds(1000);
    write_quantum(16'd500);
    test_random_rounds(1400);
    idling = 1'b0;             // last stretch at full rate
    test_random_rounds(1650);

    drain();
    $display("covered %0d items, %0d results: %0d grant requests, %0d excess grants",
             n_items, n_results, n_requests, n_excess);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/drr_pkg.sv
rtl/core/drr_ctrl.sv
rtl/core/drr_dp.sv
rtl/core/deficit_round_robin_scheduler.sv
test/deficit_round_robin_scheduler_tb.sv
